// ===== src/pt_pkg.sv =====
package pt_pkg;

  localparam int unsigned SINE_ROM_DEPTH_DEF = 1024;

  localparam int unsigned SAMPLE_W = 16;

  // pi/2 in unsigned Q62
  localparam logic [63:0] PIHALF_Q62 = 64'h6487_ED51_10B4_611A;

  localparam int unsigned SERIES_TERMS = 15;

  // (n-1)*n for the odd Taylor terms n = 3 .. 31
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] alpha_in;
    logic signed [SAMPLE_W-1:0] beta_in;
    logic        [SAMPLE_W-1:0] angle;
  } pt_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] direct;
    logic signed [SAMPLE_W-1:0] quadrature;
    logic                       clipped;
  } pt_out_t;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

endpackage

// ===== src/pt_stream_if.sv =====
interface pt_in_if import pt_pkg::*; ();
  logic   valid;
  logic   ready;
  pt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pt_out_if import pt_pkg::*; ();
  logic    valid;
  logic    ready;
  pt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/park_transform_core.sv =====
// Park transform, one (alpha, beta, angle) beat in, one (d, q) beat out.
// Registered pipeline from input beat to result valid: index, sine ROM read,
// multiply, round and saturate, each a register stage.
// Throughput: one beat per cycle; a stalled output holds the pipe, and any
// empty stage still takes a beat.
// Reset: synchronous active-low rst_n clears all stage valid bits.
module park_transform_core import pt_pkg::*; #(
  parameter int unsigned SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
  input logic   clk,
  input logic   rst_n,
  pt_in_if.sink   in_bus,
  pt_out_if.source out_bus
);

  localparam int unsigned IDX_W  = $clog2(SINE_ROM_DEPTH);
  localparam int unsigned PROD_W = SAMPLE_W + IDX_W;
  localparam logic [63:0] ROM_DEPTH_W64 = 64'(SINE_ROM_DEPTH);
  localparam logic [PROD_W-1:0] DEPTH_MUL = PROD_W'(SINE_ROM_DEPTH);
  localparam logic [IDX_W:0] DEPTH_IDX   = (IDX_W+1)'(SINE_ROM_DEPTH);
  localparam logic [IDX_W:0] QUARTER_IDX = (IDX_W+1)'(SINE_ROM_DEPTH / 4);

  function automatic logic [15:0] quad_mag(input int unsigned r);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  units;
    logic [127:0] p;
    if (r == 0) begin
      return 16'd0;
    end
    if (r * 3 == SINE_ROM_DEPTH) begin
      return 16'd16384;
    end
    x = 64'(r) * (PIHALF_Q62 / ROM_DEPTH_W64)
      + (64'(r) * (PIHALF_Q62 % ROM_DEPTH_W64)) / ROM_DEPTH_W64;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int i = 0; i < SERIES_TERMS; i++) begin
      term = mul_q62(term, x2) / SERIES_DIV[i];
      if (i % 2 == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    p     = 128'd32767 * {64'd0, sum};
    units = p[125:62];
    if (p[61]) begin
      units = units + 64'd1;
    end
    if (units > 64'd32767) begin
      units = 64'd32767;
    end
    return units[15:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
    int unsigned m;
    int unsigned quad;
    int unsigned r;
    logic [15:0] mag;
    m    = 4 * k;
    quad = m / SINE_ROM_DEPTH;
    r    = m % SINE_ROM_DEPTH;
    if (quad % 2 == 1) begin
      r = SINE_ROM_DEPTH - r;
    end
    mag = quad_mag(r);
    if ((quad / 2) % 2 == 1) begin
      return -$signed(mag);
    end
    return $signed(mag);
  endfunction

  logic signed [SAMPLE_W-1:0] sine_rom [SINE_ROM_DEPTH];

  for (genvar k = 0; k < SINE_ROM_DEPTH; k++) begin : g_rom
    localparam logic signed [SAMPLE_W-1:0] ENTRY = sine_entry(k);
    assign sine_rom[k] = ENTRY;
  end

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_bus.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_bus.ready = en1;

  // stage 1: ROM indices
  logic [PROD_W-1:0] scaled;
  logic [IDX_W-1:0]  si_nxt;
  logic [IDX_W:0]    ci_sum;
  logic [IDX_W-1:0]  ci_nxt;

  assign scaled = PROD_W'(in_bus.data.angle) * DEPTH_MUL;
  assign si_nxt = scaled[SAMPLE_W +: IDX_W];
  assign ci_sum = {1'b0, si_nxt} + QUARTER_IDX;
  assign ci_nxt = (ci_sum >= DEPTH_IDX) ? IDX_W'(ci_sum - DEPTH_IDX) : ci_sum[IDX_W-1:0];

  logic [IDX_W-1:0]           si_r, ci_r;
  logic signed [SAMPLE_W-1:0] alpha1_r, beta1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      si_r     <= si_nxt;
      ci_r     <= ci_nxt;
      alpha1_r <= in_bus.data.alpha_in;
      beta1_r  <= in_bus.data.beta_in;
    end
  end

  // stage 2: sine and cosine read
  logic signed [SAMPLE_W-1:0] sin_r, cos_r, alpha2_r, beta2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sin_r    <= sine_rom[si_r];
      cos_r    <= sine_rom[ci_r];
      alpha2_r <= alpha1_r;
      beta2_r  <= beta1_r;
    end
  end

  // stage 3: products
  logic signed [2*SAMPLE_W-1:0] ac_r, bs_r, bc_r, as_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      ac_r <= alpha2_r * cos_r;
      bs_r <= beta2_r * sin_r;
      bc_r <= beta2_r * cos_r;
      as_r <= alpha2_r * sin_r;
    end
  end

  // stage 4: round, shift and saturate
  function automatic logic [SAMPLE_W:0] round_sat(input logic signed [2*SAMPLE_W:0] v);
    logic signed [2*SAMPLE_W+1:0] biased;
    logic signed [2*SAMPLE_W-14:0] shifted;
    biased  = (2*SAMPLE_W+2)'(v) + (2*SAMPLE_W+2)'(16384);
    shifted = biased[2*SAMPLE_W+1:15];
    if (shifted > (2*SAMPLE_W-13)'(32767)) begin
      return {1'b1, 16'h7FFF};
    end
    if (shifted < -(2*SAMPLE_W-13)'(32768)) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, shifted[SAMPLE_W-1:0]};
  endfunction

  logic signed [2*SAMPLE_W:0] sum_d, sum_q;
  logic [SAMPLE_W:0]          res_d, res_q;
  pt_out_t                    out_nxt;
  pt_out_t                    out_r;

  assign sum_d = (2*SAMPLE_W+1)'(ac_r) + (2*SAMPLE_W+1)'(bs_r);
  assign sum_q = (2*SAMPLE_W+1)'(bc_r) - (2*SAMPLE_W+1)'(as_r);
  assign res_d = round_sat(sum_d);
  assign res_q = round_sat(sum_q);

  always_comb begin
    out_nxt.direct     = res_d[SAMPLE_W-1:0];
    out_nxt.quadrature = res_q[SAMPLE_W-1:0];
    out_nxt.clipped    = res_d[SAMPLE_W] | res_q[SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_r <= out_nxt;
    end
  end

  assign out_bus.valid = v4_r;
  assign out_bus.data  = out_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_bus.valid)
    else $error("result valid after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (v1_r && v2_r && v3_r && v4_r && !out_bus.ready))
    else $error("input stalled with a free stage");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.data.clipped |->
      (out_bus.data.direct == 16'sh7FFF || out_bus.data.direct == -16'sh8000 ||
       out_bus.data.quadrature == 16'sh7FFF || out_bus.data.quadrature == -16'sh8000))
    else $error("clip flag without a saturated result");

endmodule
